>>> src/apa_pkg.sv
// ----------------------------------------------------------------------------
// apa_pkg
// Shared types, constants and helpers of the address pool allocator.
// ----------------------------------------------------------------------------
package apa_pkg;

	// host bits the tree is built for
	localparam int HostBits = 8;
	localparam int IdxW     = HostBits + 1;
	localparam int TreeSize = 1 << IdxW;
	localparam int HW       = $clog2(HostBits + 1);
	localparam int FreeW    = (HostBits + 1 > 9) ? HostBits + 1 : 9;

	// command codes on the input port
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_INIT  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_NET    = 2'd0;
	localparam logic [1:0] CFG_PREFIX = 2'd1;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_INIT,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		RES_OK          = 2'd0,
		RES_EXHAUSTED   = 2'd1,
		RES_DOUBLE_FREE = 2'd2,
		RES_RESERVED    = 2'd3
	} res_t;

	// classified request between front and back
	typedef struct packed {
		op_t                 op;
		logic [HostBits-1:0] want;
	} item_t;

	// host bits in use for a prefix, saturated to the tree
	function automatic logic [HW-1:0] sat_bits(input logic [4:0] p);
		logic [5:0] d;
		d = 6'd32 - {1'b0, p};
		if (d < 6'd3) begin
			d = 6'd3;
		end else if (d > 6'(HostBits)) begin
			d = 6'(HostBits);
		end
		return HW'(d);
	endfunction

	// free host parts of a fresh pool
	function automatic logic [FreeW-1:0] pool_free(input logic [HW-1:0] h);
		return (FreeW'(1) << h) - FreeW'(3);
	endfunction

endpackage

>>> src/apa_front.sv
// ----------------------------------------------------------------------------
// apa_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module apa_front import apa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          command,
	input  logic                has_request,
	input  logic [31:0]         address,
	output logic                q_valid,
	output item_t               q_item,
	input  logic                q_pop
);

	item_t      fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       do_push, do_pop;

	// classify the request
	always_comb begin
		cls.want = address[HostBits-1:0];
		unique case (command)
			CMD_ALLOC: begin
				cls.op = OP_ALLOC;
				if (!has_request) cls.want = '0;
			end
			CMD_FREE: cls.op = OP_FREE;
			CMD_INIT: cls.op = OP_INIT;
			default:  cls.op = OP_NOP;
		endcase
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = fifo_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wp_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

>>> src/apa_back.sv
// ----------------------------------------------------------------------------
// apa_back
// Executes requests on the full-mark tree and holds the result register.
// ----------------------------------------------------------------------------
module apa_back import apa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  item_t               q_item,
	output logic                q_pop,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          status,
	output logic [31:0]         assigned_address,
	output logic [8:0]          free_count
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_CLR    = 11'b00000000010,
		S_RSV    = 11'b00000000100,
		S_A_LEAF = 11'b00000001000,
		S_A_ROOT = 11'b00000010000,
		S_W_RD   = 11'b00000100000,
		S_W_DEC  = 11'b00001000000,
		S_M_RD   = 11'b00010000000,
		S_M_WR   = 11'b00100000000,
		S_F_LEAF = 11'b01000000000,
		S_C_WR   = 11'b10000000000
	} fsm_t;

	logic                full_mem [TreeSize];
	logic                rd_q;
	fsm_t                state_q;
	logic [IdxW-1:0]     node_q;
	logic                cur_q;
	logic [HW-1:0]       lvl_q;
	logic [HW-1:0]       h_q;
	logic [1:0]          rcnt_q;
	logic                init_cmd_q;
	logic [HostBits-1:0] host_q;
	logic [FreeW-1:0]    free_q;
	logic [31:0]         net_q;
	logic [4:0]          pfx_q;
	logic                out_valid_q;
	res_t                out_status_q;
	logic [31:0]         out_addr_q;

	logic                we, wdata;
	logic [IdxW-1:0]     waddr, raddr;
	logic [IdxW-1:0]     base, hm_i;
	logic [HostBits-1:0] hm, want_m;
	logic [IdxW-1:0]     child;
	logic                take;
	logic                rsv_hit;

	// pool geometry
	assign base    = IdxW'(1) << h_q;
	assign hm_i    = base - IdxW'(1);
	assign hm      = hm_i[HostBits-1:0];
	assign want_m  = q_item.want & hm;
	assign child   = {node_q[IdxW-2:0], rd_q};
	assign take    = (state_q == S_IDLE) && q_valid && !out_valid_q;
	assign q_pop   = take;
	assign rsv_hit = (want_m == '0) || (want_m == hm) || (want_m == hm - HostBits'(1));

	// memory port control
	always_comb begin
		we    = 1'b0;
		wdata = 1'b0;
		waddr = node_q;
		raddr = base | {1'b0, want_m};
		unique case (state_q)
			S_CLR: we = 1'b1;
			S_RSV: begin
				we    = 1'b1;
				wdata = 1'b1;
				unique case (rcnt_q)
					2'd0: waddr = base;
					2'd1: waddr = base | hm_i;
					2'd2: waddr = base | (hm_i - IdxW'(1));
					default: waddr = (base | hm_i) >> 1;
				endcase
			end
			S_A_LEAF: begin
				raddr = IdxW'(1);
				we    = !rd_q;
				wdata = 1'b1;
				waddr = base | {1'b0, host_q};
			end
			S_W_RD: raddr = node_q << 1;
			S_W_DEC: begin
				we    = (HW'(lvl_q + HW'(1)) == h_q);
				wdata = 1'b1;
				waddr = child;
			end
			S_M_RD: raddr = node_q ^ IdxW'(1);
			S_M_WR: begin
				we    = 1'b1;
				wdata = cur_q & rd_q;
				waddr = node_q >> 1;
			end
			S_C_WR: we = 1'b1;
			default: ;
		endcase
	end

	// full-mark memory
	always_ff @(posedge clk) begin
		if (we) full_mem[waddr] <= wdata;
		rd_q <= full_mem[raddr];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && (q_item.op == OP_FREE) && rsv_hit) begin
			out_status_q <= RES_RESERVED;
			out_addr_q   <= '0;
		end else if (take && (q_item.op == OP_NOP)) begin
			out_status_q <= RES_OK;
			out_addr_q   <= '0;
		end else if (state_q == S_RSV) begin
			out_status_q <= RES_OK;
			out_addr_q   <= '0;
		end else if ((state_q == S_A_ROOT) && rd_q) begin
			out_status_q <= RES_EXHAUSTED;
			out_addr_q   <= '0;
		end else if ((state_q == S_F_LEAF) && !rd_q) begin
			out_status_q <= RES_DOUBLE_FREE;
			out_addr_q   <= '0;
		end else if (state_q == S_C_WR) begin
			out_status_q <= RES_OK;
			out_addr_q   <= '0;
		end else if ((state_q == S_M_RD) && (node_q == IdxW'(1))) begin
			out_status_q <= RES_OK;
			out_addr_q   <= (net_q & ~32'(hm_i)) | 32'(host_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			node_q      <= '0;
			cur_q       <= 1'b0;
			lvl_q       <= '0;
			h_q         <= sat_bits(5'd24);
			rcnt_q      <= 2'd0;
			init_cmd_q  <= 1'b0;
			host_q      <= '0;
			free_q      <= '0;
			net_q       <= '0;
			pfx_q       <= 5'd24;
			out_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid) begin
				if (cfg_index == CFG_NET) net_q <= cfg_data;
				else if (cfg_index == CFG_PREFIX) pfx_q <= cfg_data[4:0];
			end
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						host_q <= want_m;
						unique case (q_item.op)
							OP_INIT: begin
								h_q        <= sat_bits(pfx_q);
								node_q     <= '0;
								init_cmd_q <= 1'b1;
								state_q    <= S_CLR;
							end
							OP_ALLOC: begin
								node_q  <= base | {1'b0, want_m};
								state_q <= S_A_LEAF;
							end
							OP_FREE: begin
								node_q <= base | {1'b0, want_m};
								if (rsv_hit) out_valid_q <= 1'b1;
								else state_q <= S_F_LEAF;
							end
							default: out_valid_q <= 1'b1;
						endcase
					end
				end
				S_CLR: begin
					node_q <= node_q + IdxW'(1);
					if (node_q == IdxW'(TreeSize - 1)) begin
						rcnt_q  <= 2'd0;
						state_q <= S_RSV;
					end
				end
				S_RSV: begin
					rcnt_q <= rcnt_q + 2'd1;
					if (rcnt_q == 2'd3) begin
						free_q  <= pool_free(h_q);
						if (init_cmd_q) out_valid_q <= 1'b1;
						init_cmd_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_A_LEAF: begin
					if (!rd_q) begin
						node_q  <= base | {1'b0, host_q};
						cur_q   <= 1'b1;
						if (free_q != '0) free_q <= free_q - FreeW'(1);
						state_q <= S_M_RD;
					end else begin
						state_q <= S_A_ROOT;
					end
				end
				S_A_ROOT: begin
					if (rd_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						node_q  <= IdxW'(1);
						lvl_q   <= '0;
						state_q <= S_W_RD;
					end
				end
				S_W_RD: state_q <= S_W_DEC;
				S_W_DEC: begin
					node_q <= child;
					lvl_q  <= lvl_q + HW'(1);
					if (HW'(lvl_q + HW'(1)) == h_q) begin
						host_q  <= child[HostBits-1:0] & hm;
						cur_q   <= 1'b1;
						if (free_q != '0) free_q <= free_q - FreeW'(1);
						state_q <= S_M_RD;
					end else begin
						state_q <= S_W_RD;
					end
				end
				S_M_RD: begin
					if (node_q == IdxW'(1)) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_M_WR;
					end
				end
				S_M_WR: begin
					node_q  <= node_q >> 1;
					cur_q   <= cur_q & rd_q;
					state_q <= S_M_RD;
				end
				S_F_LEAF: begin
					if (!rd_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_C_WR;
					end
				end
				S_C_WR: begin
					if (node_q == IdxW'(1)) begin
						free_q      <= free_q + FreeW'(1);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						node_q <= node_q >> 1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty            = !out_valid_q;
	assign status           = out_status_q;
	assign assigned_address = out_addr_q;
	assign free_count       = free_q[8:0];

	// only a successful allocate carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q != RES_OK) |-> out_addr_q == '0)
		else $error("address on a failed request");

	// the walk never goes below the active leaves
	a_walk_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_W_DEC |-> lvl_q < h_q)
		else $error("walk past leaf level");

	// free count never exceeds a fresh pool
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> free_q <= pool_free(h_q))
		else $error("free count beyond pool size");

	// no new request is taken while a result waits
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !q_pop)
		else $error("request taken over a waiting result");

endmodule

>>> src/address_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// address_pool_allocator_unit
// Subnet host-address pool allocator over a binary tree of full marks.
// ----------------------------------------------------------------------------
// Requests are queued two deep and carried out one at a time on a 1-bit
// tree memory with one registered read and one write per cycle. A reserved
// free or the unused command is answered without a tree access; a double
// free is found at the leaf and an exhausted pool at the root. An allocate
// of a free requested address marks the leaf and runs the upward mark walk;
// an allocate that searches runs a downward walk then the mark walk; a free
// clears the marks from the leaf up to the root. Init and reset run a
// clearing pass over all 512 tree entries plus 4 reserve writes, during
// which no request is carried out, while requests can still be queued and
// configuration written.
module address_pool_allocator_unit import apa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic        has_request,
	input  logic [31:0] address,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] assigned_address,
	output logic [8:0]  free_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic  q_valid, q_pop;
	item_t q_item;

	assign cfg_ready = 1'b1;

	// front: accept and classify
	apa_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .has_request(has_request), .address(address),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	// back: tree walks and result register
	apa_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .empty(empty), .pop(pop), .status(status),
		.assigned_address(assigned_address), .free_count(free_count)
	);

endmodule
